### src/io_block_offset_generator_macros.svh
// Assertion macros for the block offset generator.
`ifndef IO_BLOCK_OFFSET_GENERATOR_MACROS_SVH
`define IO_BLOCK_OFFSET_GENERATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define IOBOG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define IOBOG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/iobog_pkg.sv
// Shared constants, types and microcode table of the block offset generator.
`default_nettype none

package iobog_pkg;

  localparam int unsigned OFFSET_BITS   = 48;
  localparam int unsigned OUT_BITS      = 48;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned HALF_BITS     = 32;
  localparam int unsigned BSIZE_BITS    = 25;
  localparam int unsigned SPAN_BITS     = 32;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned DIV_STEPS     = SPAN_BITS;
  localparam int unsigned DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int unsigned STEP_BITS     = 6;

  localparam logic [WORD_BITS-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_BITS-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_BITS-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEED        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_OFF    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_OFF     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLK_BYTES   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPAN_BLOCKS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WR_LOAD     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANDOM_MODE = 3'd6;

  localparam logic [STEP_BITS-1:0] ST_WAIT  = 6'd0;
  localparam logic [STEP_BITS-1:0] ST_MODE  = 6'd16;
  localparam logic [STEP_BITS-1:0] ST_RND   = 6'd18;
  localparam logic [STEP_BITS-1:0] ST_DIV   = 6'd29;
  localparam logic [STEP_BITS-1:0] ST_MIDX  = 6'd30;
  localparam logic [STEP_BITS-1:0] ST_OUT   = 6'd36;
  localparam logic [STEP_BITS-1:0] ST_IDX0  = 6'd38;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SEED,
    OP_XS30,
    OP_XS27,
    OP_MLL,
    OP_MLH,
    OP_MHL,
    OP_LDCTR,
    OP_ADDCTR,
    OP_SEQ,
    OP_STEPCTR,
    OP_DIVINIT,
    OP_DIV,
    OP_MIDX,
    OP_OFF,
    OP_CLRREM,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_NO_RESTART,
    C_NO_WRITE,
    C_RANDOM,
    C_SPAN_LE1,
    C_DIV_BUSY,
    C_OUT_FREE
  } cond_e;

  typedef enum logic {
    A_Z,
    A_BSIZE
  } asel_e;

  typedef enum logic [1:0] {
    K_GAMMA,
    K_MIXA,
    K_MIXB
  } ksel_e;

  typedef struct packed {
    op_e                  op;
    cond_e                cond;
    asel_e                asel;
    ksel_e                ksel;
    logic [STEP_BITS-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   seed;
    logic [OFFSET_BITS-1:0] base_off;
    logic [OFFSET_BITS-1:0] end_off;
    logic [BSIZE_BITS-1:0]  blk_bytes;
    logic [SPAN_BITS-1:0]   span_blocks;
    logic                   wr_load;
    logic                   random_mode;
  } cfg_t;

  function automatic ctrl_t cw(input op_e op, input cond_e cond,
                               input logic [STEP_BITS-1:0] target,
                               input asel_e asel, input ksel_e ksel);
    ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.asel   = asel;
    w.ksel   = ksel;
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_t w;
    case (step)
      // dispatch
      6'd0:  w = cw(OP_NOP,     C_NO_INPUT,   ST_WAIT, A_Z,     K_GAMMA);
      6'd1:  w = cw(OP_NOP,     C_NO_RESTART, ST_MODE, A_Z,     K_GAMMA);
      // restart: counter = mix(seed + gamma), position = base offset; write load adds block bytes * gamma
      6'd2:  w = cw(OP_SEED,    C_NO_INPUT,   6'd3,    A_Z,     K_GAMMA);
      6'd3:  w = cw(OP_XS30,    C_ALWAYS,     6'd4,    A_Z,     K_GAMMA);
      6'd4:  w = cw(OP_MLL,     C_ALWAYS,     6'd5,    A_Z,     K_MIXA);
      6'd5:  w = cw(OP_MLH,     C_ALWAYS,     6'd6,    A_Z,     K_MIXA);
      6'd6:  w = cw(OP_MHL,     C_ALWAYS,     6'd7,    A_Z,     K_MIXA);
      6'd7:  w = cw(OP_XS27,    C_ALWAYS,     6'd8,    A_Z,     K_GAMMA);
      6'd8:  w = cw(OP_MLL,     C_ALWAYS,     6'd9,    A_Z,     K_MIXB);
      6'd9:  w = cw(OP_MLH,     C_ALWAYS,     6'd10,   A_Z,     K_MIXB);
      6'd10: w = cw(OP_MHL,     C_ALWAYS,     6'd11,   A_Z,     K_MIXB);
      6'd11: w = cw(OP_LDCTR,   C_NO_WRITE,   ST_MODE, A_Z,     K_GAMMA);
      6'd12: w = cw(OP_MLL,     C_ALWAYS,     6'd13,   A_BSIZE, K_GAMMA);
      6'd13: w = cw(OP_MLH,     C_ALWAYS,     6'd14,   A_BSIZE, K_GAMMA);
      6'd14: w = cw(OP_MHL,     C_ALWAYS,     6'd15,   A_BSIZE, K_GAMMA);
      6'd15: w = cw(OP_ADDCTR,  C_ALWAYS,     ST_MODE, A_Z,     K_GAMMA);
      // mode select
      6'd16: w = cw(OP_NOP,     C_RANDOM,     ST_RND,  A_Z,     K_GAMMA);
      6'd17: w = cw(OP_SEQ,     C_ALWAYS,     ST_OUT,  A_Z,     K_GAMMA);
      // random draw
      6'd18: w = cw(OP_NOP,     C_SPAN_LE1,   ST_IDX0, A_Z,     K_GAMMA);
      6'd19: w = cw(OP_STEPCTR, C_ALWAYS,     6'd20,   A_Z,     K_GAMMA);
      6'd20: w = cw(OP_XS30,    C_ALWAYS,     6'd21,   A_Z,     K_GAMMA);
      6'd21: w = cw(OP_MLL,     C_ALWAYS,     6'd22,   A_Z,     K_MIXA);
      6'd22: w = cw(OP_MLH,     C_ALWAYS,     6'd23,   A_Z,     K_MIXA);
      6'd23: w = cw(OP_MHL,     C_ALWAYS,     6'd24,   A_Z,     K_MIXA);
      6'd24: w = cw(OP_XS27,    C_ALWAYS,     6'd25,   A_Z,     K_GAMMA);
      6'd25: w = cw(OP_MLL,     C_ALWAYS,     6'd26,   A_Z,     K_MIXB);
      6'd26: w = cw(OP_MLH,     C_ALWAYS,     6'd27,   A_Z,     K_MIXB);
      6'd27: w = cw(OP_MHL,     C_ALWAYS,     6'd28,   A_Z,     K_MIXB);
      6'd28: w = cw(OP_DIVINIT, C_ALWAYS,     ST_DIV,  A_Z,     K_GAMMA);
      6'd29: w = cw(OP_DIV,     C_DIV_BUSY,   ST_DIV,  A_Z,     K_GAMMA);
      6'd30: w = cw(OP_MIDX,    C_ALWAYS,     6'd31,   A_Z,     K_GAMMA);
      6'd31: w = cw(OP_OFF,     C_NO_WRITE,   ST_OUT,  A_Z,     K_GAMMA);
      6'd32: w = cw(OP_MLL,     C_ALWAYS,     6'd33,   A_BSIZE, K_GAMMA);
      6'd33: w = cw(OP_MLH,     C_ALWAYS,     6'd34,   A_BSIZE, K_GAMMA);
      6'd34: w = cw(OP_MHL,     C_ALWAYS,     6'd35,   A_BSIZE, K_GAMMA);
      6'd35: w = cw(OP_ADDCTR,  C_ALWAYS,     ST_OUT,  A_Z,     K_GAMMA);
      // emit word, hold while the output register is full
      6'd36: w = cw(OP_EMIT,    C_OUT_FREE,   ST_WAIT, A_Z,     K_GAMMA);
      6'd37: w = cw(OP_NOP,     C_ALWAYS,     ST_OUT,  A_Z,     K_GAMMA);
      // single block: index zero
      6'd38: w = cw(OP_CLRREM,  C_ALWAYS,     ST_MIDX, A_Z,     K_GAMMA);
      default: w = cw(OP_NOP,   C_ALWAYS,     ST_WAIT, A_Z,     K_GAMMA);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/iobog_datapath.sv
// Datapath of the block offset generator: mixer, shared multiplier, divider, position.
`default_nettype none

module iobog_datapath import iobog_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ctrl_t                  ctrl_i,
  input  wire cfg_t                   cfg_i,
  output logic [OFFSET_BITS-1:0]      offset_o,
  output logic                        div_last_o
);

  logic [WORD_BITS-1:0]    z_q, z_d;
  logic [WORD_BITS-1:0]    acc_q, acc_d;
  logic [WORD_BITS-1:0]    ctr_q, ctr_d;
  logic [OFFSET_BITS-1:0]  pos_q, pos_d;
  logic [OFFSET_BITS-1:0]  off_q, off_d;
  logic [SPAN_BITS-1:0]    rem_q, rem_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;

  logic [WORD_BITS-1:0]    mul_a;
  logic [WORD_BITS-1:0]    mul_k;
  logic [HALF_BITS-1:0]    mul_x;
  logic [HALF_BITS-1:0]    mul_y;
  logic [WORD_BITS-1:0]    prod;
  logic [WORD_BITS-1:0]    ctr_step;
  logic [OFFSET_BITS:0]    nxt;
  logic                    wrap;
  logic [WORD_BITS-1:0]    off_sum;
  logic [SPAN_BITS:0]      rem_sh;
  logic [SPAN_BITS:0]      rem_diff;
  logic                    rem_ge;

  always_comb begin
    mul_a = (ctrl_i.asel == A_BSIZE) ? WORD_BITS'(cfg_i.blk_bytes) : z_q;
    case (ctrl_i.ksel)
      K_MIXA:  mul_k = MIX_MUL_A;
      K_MIXB:  mul_k = MIX_MUL_B;
      default: mul_k = GOLDEN_GAMMA;
    endcase
    case (ctrl_i.op)
      OP_MLH: begin
        mul_x = mul_a[HALF_BITS-1:0];
        mul_y = mul_k[WORD_BITS-1:HALF_BITS];
      end
      OP_MHL: begin
        mul_x = mul_a[WORD_BITS-1:HALF_BITS];
        mul_y = mul_k[HALF_BITS-1:0];
      end
      OP_MIDX: begin
        mul_x = rem_q;
        mul_y = HALF_BITS'(cfg_i.blk_bytes);
      end
      default: begin
        mul_x = mul_a[HALF_BITS-1:0];
        mul_y = mul_k[HALF_BITS-1:0];
      end
    endcase
    prod = {{HALF_BITS{1'b0}}, mul_x} * {{HALF_BITS{1'b0}}, mul_y};
  end

  assign ctr_step = ctr_q + GOLDEN_GAMMA;
  assign nxt      = {1'b0, pos_q} + (OFFSET_BITS + 1)'(cfg_i.blk_bytes);
  assign wrap     = nxt[OFFSET_BITS] || (nxt[OFFSET_BITS-1:0] >= cfg_i.end_off);
  assign off_sum  = WORD_BITS'(cfg_i.base_off) + acc_q;
  assign rem_sh   = {rem_q, z_q[HALF_BITS-1]};
  assign rem_ge   = rem_sh >= {1'b0, cfg_i.span_blocks};
  assign rem_diff = rem_sh - {1'b0, cfg_i.span_blocks};

  always_comb begin
    z_d   = z_q;
    acc_d = acc_q;
    ctr_d = ctr_q;
    pos_d = pos_q;
    off_d = off_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    case (ctrl_i.op)
      OP_SEED: begin
        z_d   = cfg_i.seed + GOLDEN_GAMMA;
        pos_d = cfg_i.base_off;
      end
      OP_XS30:    z_d = z_q ^ (z_q >> 30);
      OP_XS27:    z_d = z_q ^ (z_q >> 27);
      OP_MLL:     acc_d = prod;
      OP_MLH:     acc_d = {acc_q[WORD_BITS-1:HALF_BITS] + prod[HALF_BITS-1:0],
                           acc_q[HALF_BITS-1:0]};
      OP_MHL:     z_d = {acc_q[WORD_BITS-1:HALF_BITS] + prod[HALF_BITS-1:0],
                         acc_q[HALF_BITS-1:0]};
      OP_LDCTR:   ctr_d = z_q ^ (z_q >> 31);
      OP_ADDCTR:  ctr_d = ctr_q + z_q;
      OP_SEQ: begin
        off_d = pos_q;
        pos_d = wrap ? cfg_i.base_off : nxt[OFFSET_BITS-1:0];
      end
      OP_STEPCTR: begin
        ctr_d = ctr_step;
        z_d   = ctr_step;
      end
      OP_DIVINIT: begin
        z_d   = z_q ^ (z_q >> 31);
        rem_d = '0;
        cnt_d = '0;
      end
      OP_DIV: begin
        rem_d = rem_ge ? rem_diff[SPAN_BITS-1:0] : rem_sh[SPAN_BITS-1:0];
        z_d   = {z_q[WORD_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      OP_MIDX:    acc_d = prod;
      OP_OFF:     off_d = off_sum[OFFSET_BITS-1:0];
      OP_CLRREM:  rem_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      ctr_q <= ctr_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    acc_q <= acc_d;
    off_q <= off_d;
    rem_q <= rem_d;
  end

  assign offset_o   = off_q;
  assign div_last_o = (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1));

endmodule

`default_nettype wire

### src/io_block_offset_generator.sv
// Top level of the block offset generator: config registers, sequencer, output register.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o, restart_i): one word asks for the next
//   block offset. restart_i reloads the counter from the seed and the position
//   from the base offset before this access.
// - Output channel (out_valid_o/out_ready_i, offset_o): one offset word per input word.
// - Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 seed,
//   1 base offset, 2 end offset, 3 block bytes, 4 span blocks, 5 write load,
//   6 random mode); write only while idle.
// - Microcode path per word: sequential, random with span blocks <= 1 (index zero),
//   or a full random draw with a one-bit-per-cycle remainder loop; write load adds
//   a counter update to a random word; restart adds the reseed, plus a counter
//   update under write load.
// - The next word is taken only once the sequencer is back at its wait step, so a
//   new word waits until the previous one has been emitted.
// - Each 64-bit product (low 64 bits) is built in the MLL, MLH and MHL steps on one shared 32x32 multiplier.
// - Reset: config registers take their reset values, counter and position clear.
// - A stalled receiver holds the output word; the next word is computed and waits
//   in the emit step until the output register frees.
`default_nettype none
`include "io_block_offset_generator_macros.svh"

module io_block_offset_generator import iobog_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     restart_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [OUT_BITS-1:0]           offset_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t                   cfg_q, cfg_d;
  logic [STEP_BITS-1:0]   step_q, step_d;
  logic                   restart_q;
  logic                   out_valid_q;
  logic [OUT_BITS-1:0]    out_q;
  ctrl_t                  ctrl;
  logic                   take;
  logic                   out_free;
  logic                   emit;
  logic                   div_last;
  logic [OFFSET_BITS-1:0] dp_offset;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEED:        cfg_d.seed        = cfg_data_i;
        REG_BASE_OFF:    cfg_d.base_off    = cfg_data_i[OFFSET_BITS-1:0];
        REG_END_OFF:     cfg_d.end_off     = cfg_data_i[OFFSET_BITS-1:0];
        REG_BLK_BYTES:   cfg_d.blk_bytes   = cfg_data_i[BSIZE_BITS-1:0];
        REG_SPAN_BLOCKS: cfg_d.span_blocks = cfg_data_i[SPAN_BITS-1:0];
        REG_WR_LOAD:     cfg_d.wr_load     = cfg_data_i[0];
        REG_RANDOM_MODE: cfg_d.random_mode = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed        <= '0;
      cfg_q.base_off    <= '0;
      cfg_q.end_off     <= OFFSET_BITS'(1);
      cfg_q.blk_bytes   <= BSIZE_BITS'(4096);
      cfg_q.span_blocks <= SPAN_BITS'(1);
      cfg_q.wr_load     <= 1'b0;
      cfg_q.random_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign ctrl       = ucode(step_q);
  assign in_ready_o = (step_q == ST_WAIT);
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = (ctrl.op == OP_EMIT) && out_free;

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:     take = 1'b1;
      C_NO_INPUT:   take = !in_valid_i && (step_q == ST_WAIT);
      C_NO_RESTART: take = !restart_q;
      C_NO_WRITE:   take = !cfg_q.wr_load;
      C_RANDOM:     take = cfg_q.random_mode;
      C_SPAN_LE1:   take = (cfg_q.span_blocks <= SPAN_BITS'(1));
      C_DIV_BUSY:   take = !div_last;
      C_OUT_FREE:   take = out_free;
      default:      take = 1'b0;
    endcase
    step_d = take ? ctrl.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_WAIT;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (in_valid_i && in_ready_o) begin
        restart_q <= restart_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= OUT_BITS'(dp_offset);
    end
  end

  iobog_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_q),
    .offset_o   (dp_offset),
    .div_last_o (div_last)
  );

  assign out_valid_o = out_valid_q;
  assign offset_o    = out_q;

  `IOBOG_ASSERT_NEXT(a_accept_step, in_valid_i && in_ready_o, step_q == ST_WAIT + 1'b1, "accepted word did not advance the sequencer")
  `IOBOG_ASSERT_SAME(a_emit_step, $rose(out_valid_q), $past(step_q) == ST_OUT, "output word set outside the emit step")
  `IOBOG_ASSERT_NEXT(a_div_loop, step_q == ST_DIV && !div_last, step_q == ST_DIV, "remainder loop left early")
  `IOBOG_ASSERT_SAME(a_step_range, 1'b1, step_q <= ST_IDX0, "sequencer outside its program")

endmodule

`default_nettype wire

### dv/io_block_offset_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the block offset generator: directed table, then random phases.

module io_block_offset_generator_test import iobog_pkg::*;;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned             IDLE_LIMIT = 2000;
  localparam int unsigned             WORD_GOAL  = 1900;
  localparam logic [WORD_BITS-1:0]    POS_MASK   = (64'd1 << OFFSET_BITS) - 64'd1;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic                    restart;
    logic                    known;
    logic [OUT_BITS-1:0]     want;
  } row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     restart_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [OUT_BITS-1:0]      offset_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  io_block_offset_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .offset_o   (offset_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // mirror of the generator
  cfg_t                   gen_cfg;
  logic [WORD_BITS-1:0]   gen_ctr;
  logic [OFFSET_BITS-1:0] gen_pos;

  logic [OUT_BITS-1:0] offset_due[$];
  row_t                plan[$];

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned restarts_sent;
  int unsigned draws;
  int unsigned wraps;
  int unsigned settings;
  int unsigned words_back;
  int unsigned idle_cycles;
  logic        calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [WORD_BITS-1:0] avalanche64(input logic [WORD_BITS-1:0] z);
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  task automatic predict_offset(input logic restart, output logic [OUT_BITS-1:0] off);
    logic [WORD_BITS-1:0] bs;
    logic [WORD_BITS-1:0] idx;
    logic [WORD_BITS-1:0] mixed;
    logic [WORD_BITS-1:0] sum;
    logic [WORD_BITS-1:0] nxt;
    bs = WORD_BITS'(gen_cfg.blk_bytes);
    if (restart) begin
      gen_ctr = avalanche64(gen_cfg.seed + GOLDEN_GAMMA);
      if (gen_cfg.wr_load) gen_ctr = gen_ctr + bs * GOLDEN_GAMMA;
      gen_pos = gen_cfg.base_off;
    end
    if (gen_cfg.random_mode) begin
      idx = '0;
      if (gen_cfg.span_blocks > 1) begin
        gen_ctr = gen_ctr + GOLDEN_GAMMA;
        mixed = avalanche64(gen_ctr);
        idx = {32'd0, mixed[31:0]} % WORD_BITS'(gen_cfg.span_blocks);
        draws++;
      end
      sum = (WORD_BITS'(gen_cfg.base_off) + idx * bs) & POS_MASK;
      if (gen_cfg.wr_load) gen_ctr = gen_ctr + bs * GOLDEN_GAMMA;
      off = sum[OUT_BITS-1:0];
    end else begin
      nxt = WORD_BITS'(gen_pos) + bs;
      off = gen_pos;
      if (nxt[WORD_BITS-1:OFFSET_BITS] != '0 || nxt >= WORD_BITS'(gen_cfg.end_off)) begin
        nxt = WORD_BITS'(gen_cfg.base_off);
        wraps++;
      end
      gen_pos = nxt[OFFSET_BITS-1:0];
    end
  endtask

  task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SEED:        gen_cfg.seed        = data;
      REG_BASE_OFF:    gen_cfg.base_off    = data[OFFSET_BITS-1:0];
      REG_END_OFF:     gen_cfg.end_off     = data[OFFSET_BITS-1:0];
      REG_BLK_BYTES:   gen_cfg.blk_bytes   = data[BSIZE_BITS-1:0];
      REG_SPAN_BLOCKS: gen_cfg.span_blocks = data[SPAN_BITS-1:0];
      REG_WR_LOAD:     gen_cfg.wr_load     = data[0];
      REG_RANDOM_MODE: gen_cfg.random_mode = data[0];
      default: ;
    endcase
  endtask

  // drop valid and wait out every pending offset
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (offset_due.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_word(input logic restart, input logic known,
                           input logic [OUT_BITS-1:0] want);
    int unsigned          gap;
    logic [OUT_BITS-1:0]  pred;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_offset(restart, pred);
    offset_due.push_back(known ? want : pred);
    words_sent++;
    if (restart) restarts_sent++;
  endtask

  function automatic row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] data);
    return '{kind: ROW_CFG, idx: idx, data: data, restart: 1'b0, known: 1'b0, want: '0};
  endfunction

  function automatic row_t word_known(input logic restart, input logic [OUT_BITS-1:0] want);
    return '{kind: ROW_WORD, idx: '0, data: '0, restart: restart, known: 1'b1, want: want};
  endfunction

  function automatic row_t word_calc(input logic restart);
    return '{kind: ROW_WORD, idx: '0, data: '0, restart: restart, known: 1'b0, want: '0};
  endfunction

  // receiver
  initial begin : drain_offsets
    int unsigned         gap;
    logic [OUT_BITS-1:0] want;
    out_ready_i = 1'b0;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      words_back++;
      if (offset_due.size() == 0) begin
        if (mismatches < 10) $display("offset word %h arrived with nothing due", offset_o);
        mismatches++;
      end else begin
        want = offset_due.pop_front();
        if (offset_o !== want) begin
          if (mismatches < 10)
            $display("offset word %0d: expected %h, got %h", words_back, want, offset_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("io_block_offset_generator_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    row_kind_e            last_kind;
    int unsigned          phase_len;
    logic                 restart;
    logic [WORD_BITS-1:0] rs;
    logic [WORD_BITS-1:0] bs;
    logic [WORD_BITS-1:0] data;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    calm        = 1'b0;
    mismatches  = 0;
    words_sent  = 0;
    restarts_sent = 0;
    draws       = 0;
    wraps       = 0;
    settings    = 0;
    words_back  = 0;
    gen_cfg = '{seed: '0, base_off: '0, end_off: 48'd1, blk_bytes: 25'd4096,
                span_blocks: 32'd1, wr_load: 1'b0, random_mode: 1'b0};
    gen_ctr = '0;
    gen_pos = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    plan.push_back(word_known(1'b0, 48'h0));
    plan.push_back(word_known(1'b0, 48'h0));
    plan.push_back(cfg_row(REG_BASE_OFF,    64'h1000));
    plan.push_back(cfg_row(REG_END_OFF,     64'h4000));
    plan.push_back(cfg_row(REG_BLK_BYTES,   64'h1000));
    plan.push_back(word_known(1'b1, 48'h1000));
    plan.push_back(word_known(1'b0, 48'h2000));
    plan.push_back(word_known(1'b0, 48'h3000));
    plan.push_back(word_known(1'b0, 48'h1000));
    plan.push_back(cfg_row(REG_BLK_BYTES,   64'h0));
    plan.push_back(word_known(1'b1, 48'h1000));
    plan.push_back(word_known(1'b0, 48'h1000));
    plan.push_back(cfg_row(REG_END_OFF,     64'h1000));
    plan.push_back(cfg_row(REG_BLK_BYTES,   64'h10));
    plan.push_back(word_known(1'b1, 48'h1000));
    plan.push_back(word_known(1'b0, 48'h1000));
    plan.push_back(cfg_row(REG_BASE_OFF,    64'hFFFF_FFFF_FFFF_F000));
    plan.push_back(cfg_row(REG_END_OFF,     64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_BLK_BYTES,   64'h1000));
    plan.push_back(word_known(1'b1, 48'hFFFF_FFFF_F000));
    plan.push_back(word_known(1'b0, 48'hFFFF_FFFF_F000));
    plan.push_back(cfg_row(REG_RANDOM_MODE, 64'h1));
    plan.push_back(cfg_row(REG_SPAN_BLOCKS, 64'h1));
    plan.push_back(cfg_row(REG_BASE_OFF,    64'h5000));
    plan.push_back(word_known(1'b0, 48'h5000));
    plan.push_back(cfg_row(REG_SPAN_BLOCKS, 64'h0));
    plan.push_back(word_known(1'b1, 48'h5000));
    plan.push_back(cfg_row(REG_SEED,        64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_SPAN_BLOCKS, 64'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_BLK_BYTES,   64'h100_0000));
    plan.push_back(word_calc(1'b1));
    plan.push_back(word_calc(1'b0));
    plan.push_back(word_calc(1'b0));
    plan.push_back(cfg_row(REG_WR_LOAD,     64'h1));
    plan.push_back(word_calc(1'b1));
    plan.push_back(word_calc(1'b0));
    plan.push_back(cfg_row(REG_BLK_BYTES,   64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_SEED,        64'h0));
    plan.push_back(cfg_row(REG_SPAN_BLOCKS, 64'h2));
    plan.push_back(word_calc(1'b1));
    plan.push_back(word_calc(1'b0));
    plan.push_back(cfg_row(REG_RANDOM_MODE, 64'h0));
    plan.push_back(word_calc(1'b0));
    plan.push_back(word_calc(1'b0));
    plan.push_back(cfg_row(REG_UNUSED,      64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(word_calc(1'b0));
    plan.push_back(cfg_row(REG_WR_LOAD,     64'hFFFF_FFFF_FFFF_FFFE));
    plan.push_back(cfg_row(REG_RANDOM_MODE, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(word_calc(1'b1));

    last_kind = ROW_WORD;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (last_kind == ROW_WORD) begin
          settle();
          settings++;
        end
        cfg_put(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].restart, plan[i].known, plan[i].want);
      end
      last_kind = plan[i].kind;
    end

    // random phases, each under fresh settings
    while (words_sent < WORD_GOAL) begin
      settle();
      settings++;
      calm = ($urandom_range(0, 4) == 0);
      cfg_put(REG_SEED, {$urandom, $urandom});
      case ($urandom_range(0, 3))
        0:       data = '0;
        1:       data = {$urandom, $urandom};
        2:       data = 64'($urandom_range(0, 1 << 20));
        default: data = 64'hFFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 24));
      endcase
      cfg_put(REG_BASE_OFF, data);
      case ($urandom_range(0, 5))
        0:       data = 64'd4096;
        1:       data = 64'($urandom_range(1, 64));
        2:       data = 64'h100_0000;
        3:       data = {$urandom, $urandom};
        4:       data = '0;
        default: data = 64'($urandom_range(1, 32'h1FF_FFFF));
      endcase
      cfg_put(REG_BLK_BYTES, data);
      rs = WORD_BITS'(gen_cfg.base_off);
      bs = WORD_BITS'(gen_cfg.blk_bytes);
      case ($urandom_range(0, 4))
        0, 1:    data = rs + 64'($urandom_range(1, 24)) * bs;
        2:       data = {$urandom, $urandom};
        3:       data = 64'hFFFF_FFFF_FFFF;
        default: data = rs - 64'($urandom_range(0, 3));
      endcase
      cfg_put(REG_END_OFF, data);
      case ($urandom_range(0, 5))
        0:       data = '0;
        1:       data = 64'd1;
        2:       data = 64'($urandom_range(2, 16));
        3:       data = 64'hFFFF_FFFF;
        4:       data = {$urandom, $urandom};
        default: data = 64'($urandom_range(2, 5000));
      endcase
      cfg_put(REG_SPAN_BLOCKS, data);
      cfg_put(REG_WR_LOAD, {$urandom, $urandom});
      data = {$urandom, $urandom};
      data[0] = ($urandom_range(0, 9) < 6);
      cfg_put(REG_RANDOM_MODE, data);
      if ($urandom_range(0, 5) == 0) cfg_put(REG_UNUSED, {$urandom, $urandom});

      phase_len = $urandom_range(30, 110);
      for (int unsigned k = 0; k < phase_len; k++) begin
        if (k == 0) restart = ($urandom_range(0, 3) != 0);
        else        restart = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 199) == 0) settle();
        send_word(restart, 1'b0, '0);
      end
    end

    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (offset_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    mismatches += offset_due.size();

    $display("covered %0d words (%0d restarts) under %0d register settings",
             words_sent, restarts_sent, settings);
    $display("random draws %0d, sequential wraps %0d, mismatches %0d",
             draws, wraps, mismatches);
    if (mismatches == 0) begin
      $display("io_block_offset_generator_test: clean");
    end else begin
      $display("io_block_offset_generator_test: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/iobog_pkg.sv
src/iobog_datapath.sv
src/io_block_offset_generator.sv
dv/io_block_offset_generator_test.sv
